// File: src/prlc_pkg.sv
// Shared constants, types and helper functions for the prefix route lookup counter.
// Used by every module of the block; depends on nothing else.
package prlc_pkg;

    localparam int MAX_ROUTES = 64;
    localparam int NUM_LINKS  = 16;

    localparam int ADDR_W = 32;
    localparam int SLOT_W = 6;
    localparam int LEN_W  = 6;
    localparam int LINK_W = 4;
    localparam int CFG_W  = 7;
    localparam int CNT_W  = 32;

    localparam int SLOT_AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int IDX_W   = $clog2(MAX_ROUTES + 1);
    localparam int CNT_AW  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = M_TDATA_W - LINK_W - CNT_W;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ROUTE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CNT_RD,
        ST_CNT_UPD,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [LINK_W-1:0] link;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [LINK_W-1:0] link;
    } t_route;

    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        t_route             wdata;
        logic               re;
        logic [SLOT_AW-1:0] raddr;
    } t_route_req;

    typedef struct packed {
        logic              clr;
        logic              we;
        logic [CNT_AW-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic              re;
        logic [CNT_AW-1:0] raddr;
    } t_cnt_req;

    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic              hit;
        logic [CNT_W-1:0]  count;
    } t_result;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (int'(len) > ADDR_W) ? LEN_W'(ADDR_W) : len;
    endfunction

    function automatic logic [IDX_W-1:0] clamp_count(input logic [CFG_W-1:0] cnt);
        return (int'(cnt) > MAX_ROUTES) ? IDX_W'(MAX_ROUTES) : IDX_W'(cnt);
    endfunction

    function automatic logic slot_ok(input logic [SLOT_W-1:0] slot);
        return int'(slot) < MAX_ROUTES;
    endfunction

    function automatic logic link_ok(input logic [LINK_W-1:0] link);
        return int'(link) < NUM_LINKS;
    endfunction

endpackage

// File: src/prlc_route_mem.sv
// Route table memory: prefix, length and link per slot, one write and one read port.
// Read data is registered. Depends on prlc_pkg.
module prlc_route_mem
    import prlc_pkg::*;
(
    input  logic       i_clk,
    input  t_route_req i_req,
    output t_route     o_rd_data
);

    t_route r_mem [MAX_ROUTES];
    t_route r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/prlc_count_mem.sv
// Per-link packet counter memory with valid bits; an entry not valid reads as zero.
// Read data is registered. Depends on prlc_pkg.
module prlc_count_mem
    import prlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cnt_req         i_req,
    output logic [CNT_W-1:0] o_rd_data
);

    logic [CNT_W-1:0]     r_mem [NUM_LINKS];
    logic [NUM_LINKS-1:0] r_valid;
    logic [CNT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
            r_rd_vld  <= r_valid[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: src/prlc_ctrl.sv
// Sequencer: route writes, longest-prefix scan over the route memory,
// counter read, counter read-modify-write and clear. Depends on prlc_pkg.
module prlc_ctrl
    import prlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  t_item            i_item,
    output t_route_req       o_route_req,
    input  t_route           i_route_rd,
    output t_cnt_req         o_cnt_req,
    input  logic [CNT_W-1:0] i_cnt_rd,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_route_count;
    t_item             r_item, n_item;
    logic [IDX_W-1:0]  r_limit, n_limit;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_chk, n_chk;
    logic              r_found, n_found;
    logic [LEN_W-1:0]  r_best_len, n_best_len;
    logic [LINK_W-1:0] r_best_link, n_best_link;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              accept;
    logic              match;
    logic [CNT_W-1:0]  cnt_inc;

    assign accept  = i_item_valid && o_item_ready;
    assign match   = ((r_item.addr ^ i_route_rd.prefix) & prefix_mask(i_route_rd.len)) == '0;
    assign cnt_inc = (i_cnt_rd == '1) ? i_cnt_rd : i_cnt_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_count <= '0;
        end else if (i_cfg_valid) begin
            r_route_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_limit     <= n_limit;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_best_len  <= n_best_len;
        r_best_link <= n_best_link;
        r_count     <= n_count;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.op == OP_ROUTE) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = (r_item.op == OP_READ) ? ST_CNT_UPD : ST_RESP;
            end
            ST_SCAN: begin
                if (r_idx >= r_limit && !r_chk) begin
                    n_state = ST_CNT_RD;
                end
            end
            ST_CNT_RD:  n_state = ST_CNT_UPD;
            ST_CNT_UPD: n_state = ST_RESP;
            ST_RESP: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_route_req  = '0;
        o_cnt_req    = '0;
        case (r_state)
            ST_IDLE: begin
                o_item_ready = 1'b1;
            end
            ST_EXEC: begin
                o_route_req.we           = (r_item.op == OP_WRITE) && slot_ok(r_item.slot);
                o_route_req.waddr        = SLOT_AW'(r_item.slot);
                o_route_req.wdata.prefix = r_item.addr;
                o_route_req.wdata.len    = clamp_len(r_item.len);
                o_route_req.wdata.link   = r_item.link;
                o_cnt_req.clr            = (r_item.op == OP_CLEAR);
                o_cnt_req.re             = (r_item.op == OP_READ);
                o_cnt_req.raddr          = CNT_AW'(r_item.link);
            end
            ST_SCAN: begin
                o_route_req.re    = (r_idx < r_limit);
                o_route_req.raddr = r_idx[SLOT_AW-1:0];
            end
            ST_CNT_RD: begin
                o_cnt_req.re    = 1'b1;
                o_cnt_req.raddr = CNT_AW'(r_best_link);
            end
            ST_CNT_UPD: begin
                o_cnt_req.we    = (r_item.op == OP_ROUTE) && link_ok(r_best_link);
                o_cnt_req.waddr = CNT_AW'(r_best_link);
                o_cnt_req.wdata = cnt_inc;
            end
            ST_RESP: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_item_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_item      = r_item;
        n_limit     = r_limit;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_found     = r_found;
        n_best_len  = r_best_len;
        n_best_link = r_best_link;
        n_count     = r_count;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item      = i_item;
                    n_limit     = clamp_count(r_route_count);
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_best_len  = '0;
                    n_best_link = '0;
                    n_count     = '0;
                end
            end
            ST_SCAN: begin
                if (r_idx < r_limit) begin
                    n_idx = r_idx + 1'b1;
                    n_chk = 1'b1;
                end
                if (r_chk && match && (!r_found || i_route_rd.len > r_best_len)) begin
                    n_found     = 1'b1;
                    n_best_len  = i_route_rd.len;
                    n_best_link = i_route_rd.link;
                end
            end
            ST_CNT_UPD: begin
                if (r_item.op == OP_ROUTE) begin
                    n_count = link_ok(r_best_link) ? cnt_inc : '0;
                end else begin
                    n_count = link_ok(r_item.link) ? i_cnt_rd : '0;
                end
            end
            default: begin
                n_chk = 1'b0;
            end
        endcase
    end

    assign o_res.link  = r_best_link;
    assign o_res.hit   = r_found;
    assign o_res.count = r_count;

endmodule

// File: src/prefix_route_lookup_counter.sv
// Top level of the IPv4 longest-prefix route lookup with per-link packet counters.
// Instantiates prlc_ctrl, prlc_route_mem and prlc_count_mem; depends on prlc_pkg.
//
//  channel  | direction | tdata / data                                 | tuser
//  ---------+-----------+----------------------------------------------+-----------
//  s        | in        | route_slot, address, prefix_len, link_id     | opcode
//  m        | out       | out_link, packet_count, zero pad             | hit
//  cfg      | in        | route_count                                  | -
//
// One item at a time. Write and clear run EXEC, RESP; read EXEC, CNT_UPD, RESP; route
// SCAN, CNT_RD, CNT_UPD, RESP over min(route_count, MAX_ROUTES) entries: the scan reads
// one route entry per cycle through the single read port of the route memory.
// Reset clears the counters at once through per-link valid bits; routes are undefined
// until written. A stalled result holds in the output register and the next transfer
// is taken meanwhile; it completes once the output register frees.
module prefix_route_lookup_counter
    import prlc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // route_slot, address, prefix_len, link_id
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // opcode
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // out_link, packet_count, zero pad
    output logic [M_TUSER_W-1:0] o_m_tuser,   // hit
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data   // route_count
);

    t_item            item;
    t_route_req       route_req;
    t_route           route_rd;
    t_cnt_req         cnt_req;
    logic [CNT_W-1:0] cnt_rd;
    logic             res_valid;
    t_result          res;
    logic             out_free;

    logic             r_m_tvalid;
    t_result          r_m_res;

    assign item.op   = t_op'(i_s_tuser);
    assign item.slot = i_s_tdata[SLOT_W-1:0];
    assign item.addr = i_s_tdata[SLOT_W+ADDR_W-1:SLOT_W];
    assign item.len  = i_s_tdata[SLOT_W+ADDR_W+LEN_W-1:SLOT_W+ADDR_W];
    assign item.link = i_s_tdata[S_TDATA_W-1:SLOT_W+ADDR_W+LEN_W];

    assign out_free    = !r_m_tvalid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    prlc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (i_s_tvalid),
        .o_item_ready (o_s_tready),
        .i_item       (item),
        .o_route_req  (route_req),
        .i_route_rd   (route_rd),
        .o_cnt_req    (cnt_req),
        .i_cnt_rd     (cnt_rd),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    prlc_route_mem u_route_mem (
        .i_clk     (i_clk),
        .i_req     (route_req),
        .o_rd_data (route_rd)
    );

    prlc_count_mem u_count_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (cnt_req),
        .o_rd_data (cnt_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_free) begin
            r_m_tvalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_m_res.count, r_m_res.link};
    assign o_m_tuser  = r_m_res.hit;

endmodule

// File: src/prlc_checker.sv
// Port-level checker for prefix_route_lookup_counter, attached by bind.
// Depends on prlc_pkg.
module prlc_checker
    import prlc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [M_TUSER_W-1:0] o_m_tuser
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transfer taken while an item is in work");

    a_miss_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[LINK_W-1:0] == '0)
        else $error("nonzero link without a hit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not idle after reset");

endmodule

bind prefix_route_lookup_counter prlc_checker u_prlc_checker (.*);

// File: dv/prefix_route_lookup_counter_test.sv
// Self-checking testbench for prefix_route_lookup_counter: longest-prefix route lookups,
// per-link counters, route_count settings, random stalls on both streams.
// Depends on prlc_pkg and the block's RTL only.
module prefix_route_lookup_counter_test;
    import prlc_pkg::*;

    localparam int HOLD_LEN   = 300;
    localparam int WDOG_LIMIT = 5000;
    localparam int PHASE_LEN  = 145;
    localparam int END_WAIT   = 100;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // route table and link counters as the block should hold them
    logic [ADDR_W-1:0] tbl_prefix [MAX_ROUTES];
    logic [LEN_W-1:0]  tbl_len    [MAX_ROUTES];
    logic [LINK_W-1:0] tbl_link   [MAX_ROUTES];
    logic [CNT_W-1:0]  link_pkts  [NUM_LINKS] = '{default: '0};
    int                active_routes = 0;

    logic [ADDR_W-1:0] stim_prefix [MAX_ROUTES] = '{default: '0};

    t_item   op_q    [$];
    t_result reply_q [$];
    t_item   s_cur;
    int      s_gap        = 0;
    int      m_gap        = 0;
    int      hold_left    = 0;
    int      rx_count     = 0;
    int      sent_total   = 0;
    int      errors       = 0;
    int      idle_pct     = 40;
    int      quiet_cycles = 0;

    prefix_route_lookup_counter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_tdata),   // route_slot, address, prefix_len, link_id
        .i_s_tuser   (s_tuser),   // opcode
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_tdata),   // out_link, packet_count, zero pad
        .o_m_tuser   (m_tuser),   // hit
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)   // route_count
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void predict_reply(input t_item it);
        t_result           r;
        int                n;
        int                best;
        int                i;
        logic [ADDR_W-1:0] mask;
        r    = '0;
        best = -1;
        case (it.op)
            OP_WRITE: begin
                tbl_prefix[it.slot] = it.addr;
                tbl_len[it.slot]    = (int'(it.len) > ADDR_W) ? LEN_W'(ADDR_W) : it.len;
                tbl_link[it.slot]   = it.link;
            end
            OP_ROUTE: begin
                n = (active_routes > MAX_ROUTES) ? MAX_ROUTES : active_routes;
                for (i = 0; i < n; i++) begin
                    mask = (tbl_len[i] == '0) ? '0
                                              : ({ADDR_W{1'b1}} << (ADDR_W - int'(tbl_len[i])));
                    if ((((it.addr ^ tbl_prefix[i]) & mask) == '0) &&
                        (best < 0 || int'(tbl_len[i]) > best)) begin
                        best   = int'(tbl_len[i]);
                        r.link = tbl_link[i];
                    end
                end
                r.hit = (best >= 0);
                if (int'(r.link) < NUM_LINKS) begin
                    if (link_pkts[r.link] != {CNT_W{1'b1}})
                        link_pkts[r.link] = link_pkts[r.link] + 1'b1;
                    r.count = link_pkts[r.link];
                end
            end
            OP_READ: begin
                if (int'(it.link) < NUM_LINKS) r.count = link_pkts[it.link];
            end
            default: begin
                for (i = 0; i < NUM_LINKS; i++) link_pkts[i] = '0;
            end
        endcase
        reply_q.push_back(r);
    endfunction

    function automatic t_item make_item(input t_op op, input logic [SLOT_W-1:0] slot,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [LEN_W-1:0] len,
                                        input logic [LINK_W-1:0] link);
        t_item it;
        it.op   = op;
        it.slot = slot;
        it.addr = addr;
        it.len  = len;
        it.link = link;
        return it;
    endfunction

    function automatic t_item rand_write(input int slot);
        t_item it;
        int    r;
        it.op   = OP_WRITE;
        it.slot = SLOT_W'(slot);
        it.addr = $urandom();
        r = $urandom_range(0, 99);
        if (r < 10)      it.len = '0;
        else if (r < 20) it.len = LEN_W'($urandom_range(33, 63));
        else             it.len = LEN_W'($urandom_range(1, 32));
        it.link = LINK_W'($urandom_range(0, NUM_LINKS - 1));
        stim_prefix[slot] = it.addr;
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    r;
        it.slot = SLOT_W'($urandom_range(0, 63));
        it.addr = $urandom();
        it.len  = LEN_W'($urandom_range(0, 63));
        it.link = LINK_W'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 20) begin
            it = rand_write($urandom_range(0, MAX_ROUTES - 1));
        end else if (r < 75) begin
            it.op = OP_ROUTE;
            // steer most lookups near a stored prefix so that matches are common
            if ($urandom_range(0, 9) < 7)
                it.addr = stim_prefix[$urandom_range(0, MAX_ROUTES - 1)]
                          ^ ($urandom() >> $urandom_range(0, 32));
        end else if (r < 96) begin
            it.op = OP_READ;
        end else begin
            it.op = OP_CLEAR;
        end
        return it;
    endfunction

    task automatic send(input t_item it);
        op_q.push_back(it);
        sent_total++;
    endtask

    task automatic drain();
        while (rx_count < sent_total) @(posedge clk);
    endtask

    task automatic set_route_count(input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        active_routes = value;
        cfg_valid <= 1'b0;
    endtask

    // input stream driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_reply(s_cur);
                s_gap = pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (op_q.size() != 0) begin
                    s_cur = op_q.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= {s_cur.link, s_cur.len, s_cur.addr, s_cur.slot};
                    s_tuser <= s_cur.op;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result stream monitor
    always @(posedge clk) begin : result_mon
        t_result want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("result transfer with nothing pending");
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_tdata[LINK_W-1:0] !== want.link) begin
                        $error("out_link: expected %0d, actual %0d", want.link,
                               m_tdata[LINK_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[LINK_W +: CNT_W] !== want.count) begin
                        $error("packet_count: expected %0d, actual %0d", want.count,
                               m_tdata[LINK_W +: CNT_W]);
                        errors++;
                    end
                    if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
                        $error("pad: expected 0, actual %0h", m_tdata[M_TDATA_W-1 -: M_PAD_W]);
                        errors++;
                    end
                    if (m_tuser[0] !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_tuser[0]);
                        errors++;
                    end
                end
                rx_count++;
                m_gap = pick_gap();
                if (rx_count == 200 || rx_count == 800) hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase_count [8];
        int phase_idle  [8];
        int p;
        int k;
        phase_count = '{64, 127, 0, 1, $urandom_range(2, 63), $urandom_range(65, 126), 64, 32};
        phase_idle  = '{40, 40, 40, 0, 60, 40, 40, 20};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: every packet misses and lands on link 0
        send(make_item(OP_READ,  6'd0,  32'h0000_0000, 6'd0,  4'd0));
        send(make_item(OP_ROUTE, 6'd63, 32'h0000_0000, 6'd63, 4'd15));
        send(make_item(OP_ROUTE, 6'd0,  32'hFFFF_FFFF, 6'd0,  4'd0));
        send(make_item(OP_READ,  6'd63, 32'hFFFF_FFFF, 6'd63, 4'd0));
        send(make_item(OP_READ,  6'd0,  32'h0000_0000, 6'd0,  4'd15));
        send(make_item(OP_CLEAR, 6'd63, 32'hFFFF_FFFF, 6'd63, 4'd15));
        send(make_item(OP_READ,  6'd0,  32'h0000_0000, 6'd0,  4'd0));
        // overlapping prefixes, a default route, an equal-length tie, oversized length
        send(make_item(OP_WRITE, 6'd0, 32'hC0A8_0000, 6'd16, 4'd5));
        send(make_item(OP_WRITE, 6'd1, 32'hC0A8_0100, 6'd24, 4'd9));
        send(make_item(OP_WRITE, 6'd2, 32'h0000_0000, 6'd0,  4'd3));
        send(make_item(OP_WRITE, 6'd3, 32'hC0A8_0100, 6'd24, 4'd12));
        send(make_item(OP_WRITE, 6'd4, 32'hFFFF_FFFF, 6'd63, 4'd15));
        send(make_item(OP_WRITE, 6'd5, 32'h0A00_0000, 6'd8,  4'd1));
        send(make_item(OP_WRITE, 6'd6, 32'h0000_0000, 6'd32, 4'd7));
        send(make_item(OP_WRITE, 6'd7, 32'hC0A8_0180, 6'd25, 4'd2));
        drain();
        set_route_count(8);
        send(make_item(OP_ROUTE, 6'd0, 32'hC0A8_0105, 6'd0, 4'd0));
        send(make_item(OP_ROUTE, 6'd0, 32'hC0A8_01C0, 6'd0, 4'd0));
        send(make_item(OP_ROUTE, 6'd0, 32'hC0A8_FF00, 6'd0, 4'd0));
        send(make_item(OP_ROUTE, 6'd0, 32'h0102_0304, 6'd0, 4'd0));
        send(make_item(OP_ROUTE, 6'd0, 32'hFFFF_FFFF, 6'd0, 4'd0));
        send(make_item(OP_ROUTE, 6'd0, 32'h0000_0000, 6'd0, 4'd0));
        send(make_item(OP_ROUTE, 6'd0, 32'h0A12_3456, 6'd0, 4'd0));
        send(make_item(OP_READ,  6'd0, 32'h0000_0000, 6'd0, 4'd9));
        send(make_item(OP_READ,  6'd0, 32'h0000_0000, 6'd0, 4'd15));
        send(make_item(OP_CLEAR, 6'd0, 32'h0000_0000, 6'd0, 4'd0));
        send(make_item(OP_READ,  6'd0, 32'h0000_0000, 6'd0, 4'd9));
        drain();

        // populate every slot before any count above the written range
        for (k = 0; k < MAX_ROUTES; k++) send(rand_write(k));
        drain();

        for (p = 0; p < 8; p++) begin
            set_route_count(phase_count[p]);
            idle_pct = phase_idle[p];
            for (k = 0; k < PHASE_LEN; k++) send(rand_item());
            drain();
        end

        repeat (END_WAIT) @(posedge clk);
        if (reply_q.size() != 0) begin
            $error("results still pending: expected 0, actual %0d", reply_q.size());
            errors++;
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: prefix_route_lookup_counter.f
src/prlc_pkg.sv
src/prlc_route_mem.sv
src/prlc_count_mem.sv
src/prlc_ctrl.sv
src/prefix_route_lookup_counter.sv
src/prlc_checker.sv
dv/prefix_route_lookup_counter_test.sv
